// ===== src/dmlb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmlb_pkg
// Shared types and constants of the debounced mode LED bouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmlb_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SAMPLES_PER_WINDOW = 2'd0,
        REG_WINDOW_THRESHOLD   = 2'd1,
        REG_WINDOWS_PER_STEP   = 2'd2,
        REG_UNUSED             = 2'd3
    } reg_index_t;

    localparam int unsigned CfgDataWidth = 7;

    // pattern modes
    localparam logic [1:0] MODE_PAIR   = 2'd1;
    localparam logic [1:0] MODE_TRIPLE = 2'd2;
    localparam logic [1:0] MODE_SINGLE = 2'd3;

    // reset values of the registers
    localparam logic [6:0] SAMPLES_PER_WINDOW_RST = 7'd100;
    localparam logic [6:0] WINDOW_THRESHOLD_RST   = 7'd70;
    localparam logic [3:0] WINDOWS_PER_STEP_RST   = 4'd10;
    localparam logic [5:0] PATTERN_RST            = 6'b000011;
    localparam logic [3:0] LED_OFF                = 4'b1111;

    typedef struct packed {
        logic pin_level;
    } sample_t;

    typedef struct packed {
        logic [3:0] led_drive;
        logic [1:0] mode;
        logic       step_done;
    } result_t;

    // first value of the pattern in each mode
    function automatic logic [5:0] start_pattern(input logic [1:0] mode);
        logic [5:0] pat;
        unique case (mode)
            MODE_PAIR:   pat = 6'b000011;
            MODE_TRIPLE: pat = 6'b000111;
            default:     pat = 6'b000001;
        endcase
        return pat;
    endfunction

    // far end of the pattern in each mode
    function automatic logic [5:0] end_pattern(input logic [1:0] mode);
        logic [5:0] pat;
        unique case (mode)
            MODE_PAIR:   pat = 6'b110000;
            MODE_TRIPLE: pat = 6'b111000;
            default:     pat = 6'b100000;
        endcase
        return pat;
    endfunction

    // mode sequence 1 -> 2 -> 3 -> 1
    function automatic logic [1:0] next_mode(input logic [1:0] mode);
        logic [1:0] nxt;
        unique case (mode)
            MODE_PAIR:   nxt = MODE_TRIPLE;
            MODE_TRIPLE: nxt = MODE_SINGLE;
            default:     nxt = MODE_PAIR;
        endcase
        return nxt;
    endfunction

endpackage

// ===== src/dmlb_stream_if.sv =====
// ----------------------------------------------------------------------------
// dmlb_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmlb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/debounced_mode_led_bouncer_unit.sv =====
// ----------------------------------------------------------------------------
// debounced_mode_led_bouncer_unit
// Button debounce with mode select, driving a bouncing four-LED pattern.
//
// Each sample beat carries one pin level; each one produces exactly one
// result beat in the cycle after it is taken. High samples are counted over a
// window of samples_per_window beats; a window with more than
// window_threshold high samples is high. A high window followed by a low one
// moves the mode 1 -> 2 -> 3 -> 1 and restarts the pattern moving left.
// Every windows_per_step windows the LEDs latch the inverted pattern bits
// 4..1 and the pattern shifts, bouncing at its ends. Throughput is one beat
// per cycle: the counters and the shift update in a single pass from the
// state registers into the result register. A held result stalls new samples
// only in the cycles where the sink keeps ready low. Configuration writes are
// only expected while no beat is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_mode_led_bouncer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    dmlb_stream_if.sink                    sample,
    dmlb_stream_if.source                  result,
    input  logic                           cfg_wr_en,
    input  dmlb_pkg::reg_index_t           cfg_index,
    input  logic [dmlb_pkg::CfgDataWidth-1:0] cfg_data
);
    import dmlb_pkg::*;

    // configuration registers
    logic [6:0] samples_per_window_reg;
    logic [6:0] window_threshold_reg;
    logic [3:0] windows_per_step_reg;

    // debounce and pattern state
    logic [6:0] sample_count_reg, sample_count_next;
    logic [6:0] high_count_reg,   high_count_next;
    logic [3:0] window_count_reg, window_count_next;
    logic       last_high_reg,    last_high_next;
    logic [1:0] mode_reg,         mode_next;
    logic       move_right_reg,   move_right_next;
    logic [5:0] pattern_reg,      pattern_next;
    logic [3:0] led_reg,          led_next;

    // result register
    logic    result_valid_reg;
    result_t result_data_reg, result_data_next;

    // per-beat datapath
    logic       accept;
    logic [7:0] sample_count_inc;
    logic [6:0] high_count_inc;
    logic       window_end;
    logic       window_high;
    logic [4:0] window_count_inc;
    logic       step_now;
    logic       mode_change;
    logic [1:0] mode_new;
    logic [5:0] pattern_base;
    logic       dir_base;
    logic [5:0] pattern_shift;
    logic       bounce;

    // take a new beat whenever the result slot is free or drains this cycle
    assign sample.ready = !result_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;

    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_per_window_reg <= SAMPLES_PER_WINDOW_RST;
            window_threshold_reg   <= WINDOW_THRESHOLD_RST;
            windows_per_step_reg   <= WINDOWS_PER_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_WINDOW: samples_per_window_reg <= cfg_data[6:0];
                REG_WINDOW_THRESHOLD:   window_threshold_reg   <= cfg_data[6:0];
                REG_WINDOWS_PER_STEP:   windows_per_step_reg   <= cfg_data[3:0];
                default:                ; // writes beyond the register list are dropped
            endcase
        end
    end

    always_comb
    begin
        // sample counter is one bit wider so a full count still ends the window
        sample_count_inc = {1'b0, sample_count_reg} + 8'd1;
        high_count_inc   = high_count_reg + {6'd0, sample.data.pin_level};
        // a zero window length behaves as one
        window_end       = sample_count_inc >= {1'b0, samples_per_window_reg};
        window_high      = high_count_inc > window_threshold_reg;
        window_count_inc = {1'b0, window_count_reg} + 5'd1;
        step_now         = window_end && (window_count_inc >= {1'b0, windows_per_step_reg});

        // falling edge of the debounced level advances the mode
        mode_change  = window_end && !window_high && last_high_reg;
        mode_new     = mode_change ? next_mode(mode_reg) : mode_reg;
        pattern_base = mode_change ? start_pattern(mode_new) : pattern_reg;
        dir_base     = mode_change ? 1'b0 : move_right_reg;

        // one shift, turning around at either end of the current mode
        pattern_shift = dir_base ? {1'b0, pattern_base[5:1]} : {pattern_base[4:0], 1'b0};
        bounce        = (pattern_shift == start_pattern(mode_new))
                     || (pattern_shift == end_pattern(mode_new));

        sample_count_next = window_end ? 7'd0 : sample_count_inc[6:0];
        high_count_next   = window_end ? 7'd0 : high_count_inc;
        last_high_next    = window_end ? window_high : last_high_reg;
        if (step_now)
            window_count_next = 4'd0;
        else if (window_end)
            window_count_next = window_count_inc[3:0];
        else
            window_count_next = window_count_reg;
        mode_next       = mode_new;
        pattern_next    = step_now ? pattern_shift : pattern_base;
        move_right_next = step_now ? (dir_base ^ bounce) : dir_base;
        led_next        = step_now ? ~pattern_base[4:1] : led_reg;

        result_data_next.led_drive = led_next;
        result_data_next.mode      = mode_new;
        result_data_next.step_done = step_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 7'd0;
            high_count_reg   <= 7'd0;
            window_count_reg <= 4'd0;
            last_high_reg    <= 1'b0;
            mode_reg         <= MODE_PAIR;
            move_right_reg   <= 1'b0;
            pattern_reg      <= PATTERN_RST;
            led_reg          <= LED_OFF;
        end
        else if (accept)
        begin
            sample_count_reg <= sample_count_next;
            high_count_reg   <= high_count_next;
            window_count_reg <= window_count_next;
            last_high_reg    <= last_high_next;
            mode_reg         <= mode_next;
            move_right_reg   <= move_right_next;
            pattern_reg      <= pattern_next;
            led_reg          <= led_next;
        end
    end

    // result slot: filled on accept, emptied when the sink takes the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (result.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_data_reg <= result_data_next;
    end

`ifndef SYNTH
    // mode never leaves 1..3
    a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd0)
        else $error("mode register holds zero");

    // the pattern always keeps at least one lit bit
    a_pattern_live: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_reg != 6'd0)
        else $error("pattern emptied");

    // an LED step only happens at the end of a window
    a_step_at_window_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_now |-> window_end)
        else $error("step outside a window end");

    // a held result blocks new samples
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result.ready |-> !sample.ready)
        else $error("sample taken while result stalled");

    // every accepted beat shows up as a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted beat produced no result");
`endif

endmodule

// ===== test/tb_debounced_mode_led_bouncer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_debounced_mode_led_bouncer_unit
// Self-checking bench for the debounced mode LED bouncer.
//
// Pin samples are streamed into the block and every result beat is compared
// field by field with a cycle-free software copy of the debounce, mode and
// LED bounce behavior. A short directed opening hits the zero-length and
// single-sample windows, mode changes that coincide with an LED step, and
// both bounce ends. Random phases then run under several register settings,
// including the extremes. Most windows are clean high or low runs so that
// mode changes and steps happen often; the rest is noisy or random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_debounced_mode_led_bouncer_unit;
    import dmlb_pkg::*;

    // quiet cycles before the run is declared hung
    localparam int unsigned StallLimit = 1000;
    // cycles let pass after the last result before touching the registers
    localparam int unsigned SettleCycles = 4;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    reg_index_t              cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    dmlb_stream_if #(.payload_t(sample_t)) sample_if ();
    dmlb_stream_if #(.payload_t(result_t)) result_if ();

    debounced_mode_led_bouncer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register values as last written, mirrored for the predictor
    logic [6:0] win_len_cfg;
    logic [6:0] thresh_cfg;
    logic [3:0] step_len_cfg;

    // predictor state
    logic [6:0] win_samples;
    logic [6:0] win_highs;
    logic [3:0] win_total;
    logic       prev_win_high;
    logic [1:0] cur_mode;
    logic       bounce_right;
    logic [5:0] led_pat;
    logic [3:0] led_latch;

    // pin samples waiting to be sent, LED results waiting to arrive
    sample_t pin_pend_q[$];
    result_t led_expect_q[$];

    // random idling on the sample side and stalls on the result side
    logic feed_gaps;
    logic drain_stalls;

    int unsigned samples_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned steps_seen      = 0;
    int unsigned mode_changes    = 0;
    int unsigned phases_run      = 0;
    int unsigned quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // start value of the bouncing pattern for each mode
    function automatic logic [5:0] home_pattern(input logic [1:0] m);
        logic [5:0] pat;
        case (m)
            MODE_PAIR:   pat = 6'b000011;
            MODE_TRIPLE: pat = 6'b000111;
            default:     pat = 6'b000001;
        endcase
        return pat;
    endfunction

    // advance the debounce and LED state by one pin sample
    function automatic result_t predict_leds(input logic pin);
        result_t    res;
        logic [7:0] sc;
        logic [6:0] hc;
        logic [4:0] wc;
        logic [5:0] home;
        logic [5:0] far;
        logic       hi;
        int         i;
        sc = {1'b0, win_samples} + 8'd1;
        hc = win_highs + {6'd0, pin};
        res.step_done = 1'b0;
        if (sc >= {1'b0, win_len_cfg})
        begin
            // window closes; a length of zero closes it on every sample
            hi = hc > thresh_cfg;
            wc = {1'b0, win_total} + 5'd1;
            if (!hi && prev_win_high)
            begin
                // release of the button: next mode, pattern restarts moving left
                cur_mode = (cur_mode == MODE_SINGLE) ? MODE_PAIR : cur_mode + 2'd1;
                bounce_right = 1'b0;
                led_pat = home_pattern(cur_mode);
                mode_changes++;
            end
            prev_win_high = hi;
            win_samples = '0;
            win_highs = '0;
            if (wc >= {1'b0, step_len_cfg})
            begin
                // the far end is the start value mirrored
                home = home_pattern(cur_mode);
                for (i = 0; i < 6; i++)
                    far[i] = home[5 - i];
                win_total = '0;
                led_latch = ~led_pat[4:1];
                led_pat = bounce_right ? (led_pat >> 1) : (led_pat << 1);
                if (led_pat == home || led_pat == far)
                    bounce_right = ~bounce_right;
                res.step_done = 1'b1;
                steps_seen++;
            end
            else
            begin
                win_total = wc[3:0];
            end
        end
        else
        begin
            win_samples = sc[6:0];
            win_highs = hc;
        end
        res.led_drive = led_latch;
        res.mode = cur_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // driver: one sample beat per cycle at most, taken from the pending queue
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
            sample_if.data  <= '0;
        end
        else if (!sample_if.valid || sample_if.ready)
        begin
            // the beat on the bus was taken at this edge: predict its result
            if (sample_if.valid)
            begin
                led_expect_q.push_back(predict_leds(sample_if.data.pin_level));
                samples_sent++;
            end
            // load the next beat unless a random gap falls here
            if (pin_pend_q.size() != 0 && !(feed_gaps && $urandom_range(99) < 6))
            begin
                sample_if.valid <= 1'b1;
                sample_if.data  <= pin_pend_q.pop_front();
            end
            else
            begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks every result beat against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_result(input result_t got);
        result_t want;
        if (led_expect_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: result beat with nothing expected: led %h mode %0d step %0b",
                         $time, got.led_drive, got.mode, got.step_done);
            mismatches++;
        end
        else
        begin
            want = led_expect_q.pop_front();
            results_checked++;
            if (got.led_drive !== want.led_drive || got.mode !== want.mode ||
                got.step_done !== want.step_done)
            begin
                if (mismatches < 10)
                    $display("%0t: expected led %h mode %0d step %0b, got led %h mode %0d step %0b",
                             $time, want.led_drive, want.mode, want.step_done,
                             got.led_drive, got.mode, got.step_done);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
                check_result(result_if.data);
            result_if.ready <= !(drain_stalls && $urandom_range(99) < 6);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any beat on either side means a hang
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && !(sample_if.valid && sample_if.ready) &&
            !(result_if.valid && result_if.ready))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("tb: failure");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_pins(input logic [31:0] bits, input int n);
        sample_t s;
        int      k;
        for (k = n - 1; k >= 0; k--)
        begin
            s.pin_level = bits[k];
            pin_pend_q.push_back(s);
        end
    endtask

    // block is idle once every sample is sent and every result is back
    task automatic wait_idle();
        while (pin_pend_q.size() != 0 || led_expect_q.size() != 0 ||
               sample_if.valid || result_if.valid)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // write all three registers back to back while nothing is in flight
    task automatic program_regs(input logic [6:0] spw, input logic [6:0] thr,
                                input logic [3:0] wps);
        wait_idle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SAMPLES_PER_WINDOW;
        cfg_data  <= spw;
        win_len_cfg = spw;
        @(posedge clk);
        cfg_index <= REG_WINDOW_THRESHOLD;
        cfg_data  <= thr;
        thresh_cfg = thr;
        @(posedge clk);
        cfg_index <= REG_WINDOWS_PER_STEP;
        cfg_data  <= {3'd0, wps};
        step_len_cfg = wps;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        phases_run++;
    endtask

    // queue whole debounce windows, the first one trimmed to end on a
    // window boundary; most are clean high or low runs with a few flipped
    // samples, some are plain noise
    task automatic queue_windows(input int nwin, input int flip_pct);
        int   eff;
        int   len;
        int   w;
        int   k;
        logic intent;
        logic noisy;
        eff = (win_len_cfg == 0) ? 1 : int'(win_len_cfg);
        len = (int'(win_samples) < eff) ? eff - int'(win_samples) : 1;
        for (w = 0; w < nwin; w++)
        begin
            noisy  = $urandom_range(99) < 15;
            intent = 1'($urandom_range(1));
            for (k = 0; k < len; k++)
            begin
                if (noisy)
                    push_pins($urandom_range(1), 1);
                else
                    push_pins({31'd0, intent ^ ($urandom_range(99) < flip_pct)}, 1);
            end
            len = eff;
        end
    endtask

    task automatic run_phase(input logic [6:0] spw, input logic [6:0] thr,
                             input logic [3:0] wps, input int nwin, input int flip_pct,
                             input logic gaps, input logic pause_mid);
        program_regs(spw, thr, wps);
        feed_gaps    = gaps;
        drain_stalls = gaps;
        if (pause_mid)
        begin
            // sender holds off mid-phase until every result is back
            queue_windows(nwin / 2, flip_pct);
            wait_idle();
            queue_windows(nwin - nwin / 2, flip_pct);
        end
        else
        begin
            queue_windows(nwin, flip_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [6:0] rnd_len;
        logic [6:0] rnd_thr;
        logic [3:0] rnd_step;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_SAMPLES_PER_WINDOW;
        cfg_data        = '0;
        feed_gaps       = 1'b1;
        drain_stalls    = 1'b1;

        // predictor starts from the reset state of the block
        win_len_cfg   = SAMPLES_PER_WINDOW_RST;
        thresh_cfg    = WINDOW_THRESHOLD_RST;
        step_len_cfg  = WINDOWS_PER_STEP_RST;
        win_samples   = '0;
        win_highs     = '0;
        win_total     = '0;
        prev_win_high = 1'b0;
        cur_mode      = MODE_PAIR;
        bounce_right  = 1'b0;
        led_pat       = PATTERN_RST;
        led_latch     = LED_OFF;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: a few samples, far from closing a window
        push_pins(32'b1010, 4);

        // one-sample windows and one-window steps: every 1 then 0 changes
        // the mode on the same sample as a step; three changes wrap back
        // to pair mode, then plain zeros walk the pair to its far end and back
        program_regs(7'd1, 7'd0, 4'd1);
        push_pins(32'b101010, 6);
        push_pins(32'b000000, 6);
        push_pins(32'b11, 2);

        // zero lengths act like one; a threshold of 127 never gives a high
        // window, so the pending high turns into a mode change at once
        program_regs(7'd0, 7'd127, 4'd0);
        push_pins(32'b1101, 4);

        // random phases over several settings
        run_phase(7'd3, 7'd1, 4'd1, 30, 8, 1'b1, 1'b0);
        // no random gaps or stalls on either side in this phase, but a pause mid-phase
        run_phase(7'd4, 7'd2, 4'd2, 30, 8, 1'b0, 1'b1);
        run_phase(7'd1, 7'd0, 4'd15, 45, 0, 1'b1, 1'b0);
        run_phase(7'd2, 7'd0, 4'd3, 30, 8, 1'b1, 1'b0);
        rnd_len  = 7'($urandom_range(6, 1));
        rnd_thr  = 7'($urandom_range(rnd_len, 0));
        rnd_step = 4'($urandom_range(3, 0));
        run_phase(rnd_len, rnd_thr, rnd_step, 30, 10, 1'b1, 1'b0);
        // longest window with the highest useful threshold: only a window
        // of all ones counts as high
        run_phase(7'd127, 7'd126, 4'd1, 2, 0, 1'b1, 1'b0);

        wait_idle();

        $display("tb run: %0d sample beats, %0d results checked over %0d register settings",
                 samples_sent, results_checked, phases_run + 1);
        $display("tb run: %0d led steps and %0d mode changes predicted",
                 steps_seen, mode_changes);
        if (mismatches == 0 && led_expect_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, led_expect_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/dmlb_pkg.sv
src/dmlb_stream_if.sv
src/debounced_mode_led_bouncer_unit.sv
test/tb_debounced_mode_led_bouncer_unit.sv
